>>> src/kbd_pkg.sv
// Shared types, constants and key tables for the scan code decoder with character FIFO.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package kbd_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   typedef logic [FIFO_AW-1:0]  fifo_ptr_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [OUTQ_AW-1:0]  outq_ptr_type;
   typedef logic [OUTQ_CW-1:0]  outq_cnt_type;
   typedef logic [6:0]          key_code_type;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARROW_UP   = 8'd0,
      CSR_ARROW_DOWN = 8'd1
   } csr_idx_type;

   localparam char_type     PREFIX_BYTE  = 8'hE0;
   localparam int           RELEASE_BIT  = 7;
   localparam key_code_type CODE_MASK    = 7'h7F;
   localparam key_code_type LSHIFT_CODE  = 7'h2A;
   localparam key_code_type RSHIFT_CODE  = 7'h36;
   localparam key_code_type CAPS_CODE    = 7'h3A;
   localparam key_code_type UP_CODE      = 7'h48;
   localparam key_code_type DOWN_CODE    = 7'h50;
   localparam char_type     ARROW_UP_RST = 8'd128;
   localparam char_type     ARROW_DN_RST = 8'd129;

   typedef struct packed {
      logic pop_hit;
      logic empty;
      logic queued;
      logic dropped;
   } res_flags_type;

   typedef struct packed {
      logic         wr_en;
      fifo_ptr_type wr_addr;
      char_type     wr_data;
      logic         rd_en;
      fifo_ptr_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      char_type key_out;
      logic     fifo_was_empty;
      logic     char_queued;
      logic     char_dropped;
   } rsp_beat_type;

   function automatic fifo_ptr_type fifo_next(input fifo_ptr_type p);
      fifo_ptr_type r;
      if (p == fifo_ptr_type'(FIFO_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   function automatic outq_ptr_type outq_next(input outq_ptr_type p);
      outq_ptr_type r;
      if (p == outq_ptr_type'(OUTQ_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   // Unshifted character for a make code; zero means the key has no character.
   function automatic char_type plain_char(input key_code_type code);
      char_type c;
      case (code)
         7'h01: c = 8'h1B;
         7'h02: c = 8'h31;
         7'h03: c = 8'h32;
         7'h04: c = 8'h33;
         7'h05: c = 8'h34;
         7'h06: c = 8'h35;
         7'h07: c = 8'h36;
         7'h08: c = 8'h37;
         7'h09: c = 8'h38;
         7'h0A: c = 8'h39;
         7'h0B: c = 8'h30;
         7'h0C: c = 8'h2D;
         7'h0D: c = 8'h3D;
         7'h0E: c = 8'h08;
         7'h0F: c = 8'h09;
         7'h10: c = 8'h71;
         7'h11: c = 8'h77;
         7'h12: c = 8'h65;
         7'h13: c = 8'h72;
         7'h14: c = 8'h74;
         7'h15: c = 8'h79;
         7'h16: c = 8'h75;
         7'h17: c = 8'h69;
         7'h18: c = 8'h6F;
         7'h19: c = 8'h70;
         7'h1A: c = 8'h5B;
         7'h1B: c = 8'h5D;
         7'h1C: c = 8'h0A;
         7'h1E: c = 8'h61;
         7'h1F: c = 8'h73;
         7'h20: c = 8'h64;
         7'h21: c = 8'h66;
         7'h22: c = 8'h67;
         7'h23: c = 8'h68;
         7'h24: c = 8'h6A;
         7'h25: c = 8'h6B;
         7'h26: c = 8'h6C;
         7'h27: c = 8'h3B;
         7'h28: c = 8'h27;
         7'h29: c = 8'h60;
         7'h2B: c = 8'h5C;
         7'h2C: c = 8'h7A;
         7'h2D: c = 8'h78;
         7'h2E: c = 8'h63;
         7'h2F: c = 8'h76;
         7'h30: c = 8'h62;
         7'h31: c = 8'h6E;
         7'h32: c = 8'h6D;
         7'h33: c = 8'h2C;
         7'h34: c = 8'h2E;
         7'h35: c = 8'h2F;
         7'h37: c = 8'h2A;
         7'h39: c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Shifted character for a make code.
   function automatic char_type shift_char(input key_code_type code);
      char_type c;
      case (code)
         7'h01: c = 8'h1B;
         7'h02: c = 8'h21;
         7'h03: c = 8'h40;
         7'h04: c = 8'h23;
         7'h05: c = 8'h24;
         7'h06: c = 8'h25;
         7'h07: c = 8'h5E;
         7'h08: c = 8'h26;
         7'h09: c = 8'h2A;
         7'h0A: c = 8'h28;
         7'h0B: c = 8'h29;
         7'h0C: c = 8'h5F;
         7'h0D: c = 8'h2B;
         7'h0E: c = 8'h08;
         7'h0F: c = 8'h09;
         7'h10: c = 8'h51;
         7'h11: c = 8'h57;
         7'h12: c = 8'h45;
         7'h13: c = 8'h52;
         7'h14: c = 8'h54;
         7'h15: c = 8'h59;
         7'h16: c = 8'h55;
         7'h17: c = 8'h49;
         7'h18: c = 8'h4F;
         7'h19: c = 8'h50;
         7'h1A: c = 8'h7B;
         7'h1B: c = 8'h7D;
         7'h1C: c = 8'h0A;
         7'h1E: c = 8'h41;
         7'h1F: c = 8'h53;
         7'h20: c = 8'h44;
         7'h21: c = 8'h46;
         7'h22: c = 8'h47;
         7'h23: c = 8'h48;
         7'h24: c = 8'h4A;
         7'h25: c = 8'h4B;
         7'h26: c = 8'h4C;
         7'h27: c = 8'h3A;
         7'h28: c = 8'h22;
         7'h29: c = 8'h7E;
         7'h2B: c = 8'h7C;
         7'h2C: c = 8'h5A;
         7'h2D: c = 8'h58;
         7'h2E: c = 8'h43;
         7'h2F: c = 8'h56;
         7'h30: c = 8'h42;
         7'h31: c = 8'h4E;
         7'h32: c = 8'h4D;
         7'h33: c = 8'h3C;
         7'h34: c = 8'h3E;
         7'h35: c = 8'h3F;
         7'h37: c = 8'h2A;
         7'h39: c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> src/kbd_if.sv
// Valid/ready channel interfaces: request, response and register write port.
// Depends on kbd_pkg for payload types.
`timescale 1ns / 1ps

interface kbd_req_if import kbd_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     operation;
   char_type scan_byte;

   modport source (output valid, output operation, output scan_byte, input ready);
   modport sink   (input valid, input operation, input scan_byte, output ready);
endinterface

interface kbd_rsp_if import kbd_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type key_out;
   logic     fifo_was_empty;
   logic     char_queued;
   logic     char_dropped;

   modport source (output valid, output key_out, output fifo_was_empty,
                   output char_queued, output char_dropped, input ready);
   modport sink   (input valid, input key_out, input fifo_was_empty,
                   input char_queued, input char_dropped, output ready);
endinterface

interface kbd_csr_if import kbd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   char_type             data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/keyboard_scancode_to_ascii_fifo_top.sv
// Top level of the scan code decoder with character FIFO.
// Depends on kbd_pkg, kbd_if, kbd_ctrl, kbd_fifo_mem and kbd_outq.
`timescale 1ns / 1ps

// Usage:
// The req_ch channel carries one beat per item: operation 0 hands in a Set 1 scan
// byte, operation 1 pops the oldest queued character. Every accepted beat yields
// exactly one beat on rsp_ch, in order. The csr_ch port writes the up and down
// arrow codes (index 0 and 1); it is always ready, and other indexes are ignored.
// A beat accepted on req_ch passes the read stage, where its flags and the memory read
// are registered, then the output queue. Throughput is one item per cycle while req_ch
// is ready; decode, pointer update and a single memory access (write for a queued key,
// read for a pop) all happen in the accept cycle.
// Results wait in a four-entry output queue, so the block keeps accepting while
// a result is waiting; req_ch ready drops only when that queue plus the beat in
// the read stage fill it, and no beat is lost when the receiver stalls.
// Reset empties the character FIFO, clears the prefix, shift and caps lock flags
// and sets the arrow codes to 128 and 129. The character memory itself is not
// cleared; reading never touches an entry that has not been written.

module keyboard_scancode_to_ascii_fifo_top import kbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   kbd_req_if.sink    req_ch,
   kbd_rsp_if.source  rsp_ch,
   kbd_csr_if.sink    csr_ch
);

   logic          accept;
   logic          has_room;
   mem_req_type   mem_req;
   char_type      rd_data;
   logic          st1_valid;
   res_flags_type st1_flags;
   rsp_beat_type  push_beat;

   assign req_ch.ready = has_room;
   assign accept       = req_ch.valid && has_room;

   kbd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_ch       (csr_ch),
      .accept       (accept),
      .operation    (req_ch.operation),
      .scan_byte    (req_ch.scan_byte),
      .mem_req      (mem_req),
      .st1_valid_ff (st1_valid),
      .st1_flags_ff (st1_flags)
   );

   kbd_fifo_mem u_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      push_beat.key_out        = st1_flags.pop_hit ? rd_data : '0;
      push_beat.fifo_was_empty = st1_flags.empty;
      push_beat.char_queued    = st1_flags.queued;
      push_beat.char_dropped   = st1_flags.dropped;
   end

   kbd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (st1_valid),
      .push_beat (push_beat),
      .rsp_ch    (rsp_ch),
      .has_room  (has_room)
   );

endmodule

>>> src/kbd_fifo_mem.sv
// Character FIFO storage: one write port and one registered read port.
// Depends on kbd_pkg.
`timescale 1ns / 1ps

module kbd_fifo_mem import kbd_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output char_type    rd_data_ff
);

   char_type char_fifo_mem [FIFO_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         char_fifo_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= char_fifo_mem[mem_req.rd_addr];
      end
   end

endmodule

>>> src/kbd_ctrl.sv
// Scan code decoder, FIFO pointer control, keyboard flags and arrow code registers.
// Depends on kbd_pkg and kbd_if.
`timescale 1ns / 1ps

module kbd_ctrl import kbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   kbd_csr_if.sink       csr_ch,
   input  logic          accept,
   input  logic          operation,
   input  char_type      scan_byte,
   output mem_req_type   mem_req,
   output logic          st1_valid_ff,
   output res_flags_type st1_flags_ff
);

   fifo_ptr_type  wr_ptr_ff, wr_ptr_in;
   fifo_ptr_type  rd_ptr_ff, rd_ptr_in;
   logic          prefix_ff, prefix_in;
   logic          shift_ff, shift_in;
   logic          caps_ff, caps_in;
   char_type      arrow_up_ff, arrow_dn_ff;
   res_flags_type flags_in;
   key_code_type  code;
   logic          released;
   char_type      lo_char;
   logic          is_letter;
   logic          pick_shifted;
   logic          have;
   char_type      ch;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arrow_up_ff <= ARROW_UP_RST;
         arrow_dn_ff <= ARROW_DN_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ARROW_UP:   arrow_up_ff <= csr_ch.data;
            CSR_ARROW_DOWN: arrow_dn_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign code         = scan_byte[6:0] & CODE_MASK;
   assign released     = scan_byte[RELEASE_BIT];
   assign lo_char      = plain_char(code);
   assign is_letter    = (lo_char >= 8'h61) && (lo_char <= 8'h7A);
   assign pick_shifted = is_letter ? (shift_ff ^ caps_ff) : shift_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      prefix_in = prefix_ff;
      shift_in  = shift_ff;
      caps_in   = caps_ff;
      flags_in  = '0;
      mem_req   = '0;
      mem_req.wr_addr = wr_ptr_ff;
      mem_req.rd_addr = rd_ptr_ff;
      have = 1'b0;
      ch   = '0;
      if (accept) begin
         if (op_type'(operation) == OP_POP) begin
            if (rd_ptr_ff == wr_ptr_ff) begin
               flags_in.empty = 1'b1;
            end else begin
               flags_in.pop_hit = 1'b1;
               mem_req.rd_en    = 1'b1;
               rd_ptr_in        = fifo_next(rd_ptr_ff);
            end
         end else if (scan_byte == PREFIX_BYTE) begin
            prefix_in = 1'b1;
         end else begin
            prefix_in = 1'b0;
            if (prefix_ff) begin
               // Only the up and down arrow makes mean anything after the prefix.
               if (!released && code == UP_CODE) begin
                  ch   = arrow_up_ff;
                  have = 1'b1;
               end else if (!released && code == DOWN_CODE) begin
                  ch   = arrow_dn_ff;
                  have = 1'b1;
               end
            end else if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
               shift_in = !released;
            end else if (code == CAPS_CODE) begin
               if (!released) caps_in = !caps_ff;
            end else if (!released) begin
               ch   = pick_shifted ? shift_char(code) : lo_char;
               have = (ch != '0);
            end
            if (have) begin
               if (fifo_next(wr_ptr_ff) == rd_ptr_ff) begin
                  flags_in.dropped = 1'b1;
               end else begin
                  flags_in.queued = 1'b1;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = ch;
                  wr_ptr_in       = fifo_next(wr_ptr_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         prefix_ff    <= 1'b0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         st1_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         prefix_ff    <= prefix_in;
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         st1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) st1_flags_ff <= flags_in;
   end

endmodule

>>> src/kbd_outq.sv
// Small result queue in front of the response channel; absorbs receiver stalls.
// Depends on kbd_pkg and kbd_if.
`timescale 1ns / 1ps

module kbd_outq import kbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_beat_type  push_beat,
   kbd_rsp_if.source     rsp_ch,
   output logic          has_room
);

   rsp_beat_type entry_ff [OUTQ_DEPTH];
   outq_ptr_type head_ff, head_in;
   outq_ptr_type tail_ff, tail_in;
   outq_cnt_type count_ff, count_in;
   logic         pop;
   logic [OUTQ_CW:0] pending;

   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.key_out        = entry_ff[head_ff].key_out;
   assign rsp_ch.fifo_was_empty = entry_ff[head_ff].fifo_was_empty;
   assign rsp_ch.char_queued    = entry_ff[head_ff].char_queued;
   assign rsp_ch.char_dropped   = entry_ff[head_ff].char_dropped;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   // The beat still in the memory read stage already owns a slot.
   assign pending  = {1'b0, count_ff} + {{OUTQ_CW{1'b0}}, push};
   assign has_room = (pending < (OUTQ_CW + 1)'(OUTQ_DEPTH));

   always_comb begin
      head_in  = pop  ? outq_next(head_ff) : head_ff;
      tail_in  = push ? outq_next(tail_ff) : tail_ff;
      count_in = count_ff + outq_cnt_type'(push) - outq_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[tail_ff] <= push_beat;
   end

endmodule
